// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared geometry, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  // Cells moved up by one row during a scroll; the rest are blanked
  localparam int COPY_N  = (ROWS - 2) * COLUMNS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [7:0] ATTR_RESET = 8'h0F;
  localparam int         TAB_STOP   = 8;

  // Control bytes
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // Cursor update for one put request
  typedef struct packed {
    logic [COL_W-1:0] col;     // column after the request
    logic [ROW_W-1:0] row;     // row after the request (scroll applied)
    logic             print;   // store the byte at the old cursor
    logic             bs;      // clear the character byte at the new cursor
    logic             scroll;  // move the screen up one row
  } step_t;

  // Linear cell address of a row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(COLUMNS);
    return base + ADDR_W'(col);
  endfunction

endpackage

// File: rtl/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor movement for one put request: control bytes, wrap and scroll.
// ----------------------------------------------------------------------------
module tcw_cursor (
  input  logic [6:0]     cur_col,
  input  logic [4:0]     cur_row,
  input  logic [7:0]     char_code,
  output tcw_pkg::step_t step
);
  import tcw_pkg::*;

  logic [7:0] col_w;
  logic [7:0] col_tab;
  logic [5:0] row_w;
  logic       print;
  logic       bs;
  logic       scroll;

  assign col_tab = {1'b0, cur_col} + 8'(TAB_STOP);

  always_comb begin
    col_w = {1'b0, cur_col};
    row_w = {1'b0, cur_row};
    print = 1'b0;
    bs    = 1'b0;
    // interpret the byte
    case (char_code)
      CH_BS: begin
        if (cur_col != '0) begin
          col_w = col_w - 8'd1;
          bs    = 1'b1;
        end
      end
      CH_TAB: col_w = {col_tab[7:3], 3'b000};
      CH_CR:  col_w = '0;
      CH_LF: begin
        col_w = '0;
        row_w = row_w + 6'd1;
      end
      default: begin
        print = 1'b1;
        col_w = col_w + 8'd1;
      end
    endcase
    // wrap past the last column
    if (col_w >= 8'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + 6'd1;
    end
    // scroll when the last row is reached
    scroll = (row_w >= 6'(ROWS - 1));
    if (scroll) begin
      row_w = row_w - 6'd1;
    end
  end

  assign step.col    = col_w[COL_W-1:0];
  assign step.row    = row_w[ROW_W-1:0];
  assign step.print  = print;
  assign step.bs     = bs;
  assign step.scroll = scroll;

endmodule

// File: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with cursor, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// One request is taken at a time; s_tready is high only while the block waits
// for work and the result has been taken. The path from acceptance to a valid
// result is set by the single-port-write cell memory and its address sequencer:
// a printed byte, a control byte or an unused request kind goes straight to
// S_OUT, a read passes through S_RD, a backspace through S_BS, a put that
// scrolls through S_SCROLL and S_BLANK (one cell moved or blanked per cycle),
// and a clear through S_CLEAR. After reset a clearing pass zeroes the memory
// before the first request is taken; text_attr writes are taken at any time.
module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  // Attribute register
  input  logic        text_attr_we,
  input  logic [7:0]  text_attr_wdata,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // cursor_col[6:0], cursor_row[11:7],
                                 // cell_char[19:12], cell_attr[27:20]
);
  import tcw_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RD     = 7'b0000100,
    S_BS     = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_BLANK  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COPY_N - 1);

  state_t              state;
  logic [ADDR_W-1:0]   ptr;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [7:0]          text_attr;
  logic                clr_reply;
  logic                rd_ok;
  logic [ADDR_W-1:0]   bs_addr;
  logic [7:0]          cell_char;
  logic [7:0]          cell_attr;
  // copy / blank write stage
  logic                wr_v;
  logic                wr_zero;
  logic [ADDR_W-1:0]   wr_addr;

  // cell memory
  logic [CELL_W-1:0]   mem [CELLS];
  logic [CELL_W-1:0]   rdata;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  logic                s_acc;
  req_t                req;
  logic [7:0]          char_code;
  logic [ROW_W-1:0]    read_row;
  logic [COL_W-1:0]    read_col;
  logic                rd_in_range;
  logic [ADDR_W-1:0]   rd_addr;
  step_t               step;

  assign req       = req_t'(s_tuser);
  assign char_code = s_tdata[7:0];
  assign read_row  = s_tdata[12:8];
  assign read_col  = s_tdata[19:13];

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {4'h0, cell_attr, cell_char, cur_row, cur_col};

  assign rd_in_range = (read_row < ROW_W'(ROWS)) && (read_col < COL_W'(COLUMNS));
  assign rd_addr     = rd_in_range ? cell_addr(read_row, read_col) : '0;

  tcw_cursor u_cursor (
    .cur_col   (cur_col),
    .cur_row   (cur_row),
    .char_code (char_code),
    .step      (step)
  );

  // Select the memory write for this cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = '0;
    if (wr_v) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr;
      mem_wdata = wr_zero ? '0 : rdata;
    end else begin
      case (state)
        S_CLEAR: mem_we = 1'b1;
        S_IDLE: begin
          if (s_acc && req == REQ_PUT && step.print) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(cur_row, cur_col);
            mem_wdata = {text_attr, char_code};
          end
        end
        S_BS: begin
          mem_we    = 1'b1;
          mem_waddr = bs_addr;
          mem_wdata = {rdata[15:8], 8'h00};
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // Select the memory read address
  always_comb begin
    case (state)
      S_SCROLL: mem_raddr = ptr + ADDR_W'(COLUMNS);
      S_IDLE:   mem_raddr = (req == REQ_READ) ? rd_addr : cell_addr(cur_row, step.col);
      default:  mem_raddr = ptr;
    endcase
  end

  // Cell memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= ATTR_RESET;
    end else if (text_attr_we) begin
      text_attr <= text_attr_wdata;
    end
  end

  // Write each copied or blanked cell in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_v <= 1'b0;
    end else begin
      wr_v <= (state == S_SCROLL) || (state == S_BLANK);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      clr_reply <= 1'b0;
    end else begin
      case (state)
        // zero every cell, one per cycle
        S_CLEAR: begin
          if (ptr == LAST_CELL) begin
            ptr       <= '0;
            clr_reply <= 1'b0;
            state     <= clr_reply ? S_OUT : S_IDLE;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        // take a request
        S_IDLE: begin
          if (s_acc) begin
            cell_char <= '0;
            cell_attr <= '0;
            case (req)
              REQ_PUT: begin
                cur_col <= step.col;
                cur_row <= step.row;
                bs_addr <= cell_addr(cur_row, step.col);
                ptr     <= '0;
                if (step.bs) begin
                  state <= S_BS;
                end else if (step.scroll) begin
                  state <= S_SCROLL;
                end else begin
                  state <= S_OUT;
                end
              end
              REQ_READ: begin
                rd_ok <= rd_in_range;
                state <= S_RD;
              end
              REQ_CLEAR: begin
                cur_col   <= '0;
                cur_row   <= '0;
                ptr       <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        // capture the read cell
        S_RD: begin
          if (rd_ok) begin
            cell_char <= rdata[7:0];
            cell_attr <= rdata[15:8];
          end
          state <= S_OUT;
        end
        // backspace write happens this cycle
        S_BS: state <= S_OUT;
        // move the cells of rows 1 to ROWS-2 up one row
        S_SCROLL: begin
          wr_zero <= 1'b0;
          wr_addr <= ptr;
          ptr     <= ptr + ADDR_W'(1);
          if (ptr == COPY_LAST) begin
            state <= S_BLANK;
          end
        end
        // blank the last two rows
        S_BLANK: begin
          wr_zero <= 1'b1;
          wr_addr <= ptr;
          if (ptr == LAST_CELL) begin
            ptr   <= '0;
            state <= S_OUT;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        // hold the result until taken
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Cursor never rests on the last row or past the last column
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cur_row < ROW_W'(ROWS - 1)))
    else $error("cursor row out of range");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cur_col < COL_W'(COLUMNS))
    else $error("cursor column out of range");

  // No memory write may be pending when a new request can be taken
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_v)
    else $error("write pending while idle");

  // A request never yields a result in the cycle it is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_acc |-> !m_tvalid)
    else $error("result valid too early");

endmodule
